FILE: sv/xtn_pkg.sv
// ----------------------------------------------------------------------------
// xtn_pkg
// Shared types and codes of the XML tag nesting checker: line phases, status
// codes and the result record that travels through the output queue.
// ----------------------------------------------------------------------------
package xtn_pkg;

    // Per-line parser phase
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_PR_Q    = 4'd1,
        PH_PR_SCAN = 4'd2,
        PH_PR_EQ   = 4'd3,
        PH_PR_VAL  = 4'd4,
        PH_PR_FREE = 4'd5,
        PH_SEL     = 4'd6,
        PH_CM2     = 4'd7,
        PH_CM3     = 4'd8,
        PH_CM_BODY = 4'd9,
        PH_CL_NAME = 4'd10,
        PH_OP_NAME = 4'd11,
        PH_OP_BODY = 4'd12,
        PH_DONE    = 4'd13
    } t_phase;

    // Status codes reported per line and per document
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_PR_QUOTE    = 4'd1,
        ST_PR_CLOSE    = 4'd2,
        ST_CM_OPEN     = 4'd3,
        ST_CM_CLOSE    = 4'd4,
        ST_TAG_OPEN    = 4'd5,
        ST_MISMATCH    = 4'd6,
        ST_UNTERM      = 4'd7,
        ST_OVERFLOW    = 4'd8,
        ST_NAME_LONG   = 4'd9,
        ST_DOC_OK      = 4'd10,
        ST_UNBALANCED  = 4'd11,
        ST_RSV12       = 4'd12,
        ST_RSV13       = 4'd13,
        ST_RSV14       = 4'd14,
        ST_RSV15       = 4'd15
    } t_status;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // One result transaction
    typedef struct packed {
        logic [15:0] line_number;
        t_status     status;
        logic [4:0]  open_depth;
        logic        last_result;
    } t_result;

    // One push request into the output queue
    typedef struct packed {
        logic    vld;
        t_result res;
    } t_push;

endpackage

FILE: sv/xtn_name_mem.sv
// ----------------------------------------------------------------------------
// xtn_name_mem
// Tag name byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xtn_name_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] mem [DEPTH];

    // Write name bytes
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

FILE: sv/xtn_out_fifo.sv
// ----------------------------------------------------------------------------
// xtn_out_fifo
// Four-entry result queue taking up to two pushes per cycle.
// ----------------------------------------------------------------------------
module xtn_out_fifo
    import xtn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push0,
    input  t_push      i_push1,
    input  logic       i_pop,
    output t_result    o_head,
    output logic [2:0] o_count
);

    t_result    mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] wp1;

    // Second push lands behind the first one
    assign wp1 = r_wp + {1'b0, i_push0.vld};

    always_comb begin
        n_wp  = r_wp + {1'b0, i_push0.vld} + {1'b0, i_push1.vld};
        n_rp  = r_rp + {1'b0, i_pop};
        n_cnt = r_cnt + {2'b0, i_push0.vld} + {2'b0, i_push1.vld} - {2'b0, i_pop};
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store results
    always_ff @(posedge i_clk) begin
        if (i_push0.vld) begin
            mem[r_wp] <= i_push0.res;
        end
        if (i_push1.vld) begin
            mem[wp1] <= i_push1.res;
        end
    end

    assign o_head  = mem[r_rp];
    assign o_count = r_cnt;

endmodule

FILE: sv/xml_tag_nesting_checker.sv
// ----------------------------------------------------------------------------
// xml_tag_nesting_checker
// Line-oriented XML checker: prolog, comment and tag lines, tag names held
// on a stack in a name memory, one status per line and a document verdict.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | i_valid o_ready i_text_byte i_end_of_document  | in
//  output   | o_valid i_ready o_line_number o_status         | out
//           | o_open_depth o_last_result                     |
//
// One byte per cycle is accepted. A closing-name byte reads the name memory
// in its own cycle; the compare completes on the next cycle and is forwarded.
// A result is queued at the line end or document end.
// A document end yields up to two transactions through a four-entry queue;
// input stalls while more than two entries are pending.
// Reset is synchronous; the name memory needs no clearing pass.
// ----------------------------------------------------------------------------
module xml_tag_nesting_checker
    import xtn_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int NAME_LEN    = 32,
    parameter int LINE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_document,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_line_number,
    output logic [3:0]  o_status,
    output logic [4:0]  o_open_depth,
    output logic        o_last_result
);

    localparam int MEM_DEPTH = STACK_DEPTH * NAME_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W     = $clog2(STACK_DEPTH);
    localparam int IW        = $clog2(NAME_LEN + 2);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // State
    t_phase               r_phase, n_phase;
    t_status              r_err, n_err;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                 r_open, n_open;
    logic [23:0]          r_recent, n_recent;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_mis, n_mis;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [7:0]           r_cmp_byte, n_cmp_byte;
    logic [IW-1:0]        r_len [STACK_DEPTH];

    logic                 acc, pop;
    logic                 mis_now;
    logic                 wr_en, rd_en, len_we;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [7:0]           rd_data;
    logic [TOP_W-1:0]     len_wa;
    logic [IW-1:0]        len_wd;
    logic [2:0]           q_cnt;
    t_push                push0, push1;
    t_result              head;
    logic [LINE_BITS-1:0] line_eff;
    logic [SP_W-1:0]      top;
    logic [IW-1:0]        top_len;

    assign acc     = i_valid && o_ready;
    assign o_ready = (q_cnt <= 3'd2);
    assign top     = r_sp - SP_W'(1);
    assign top_len = r_len[top[TOP_W-1:0]];
    assign line_eff = (!r_open && r_line != LINE_MAX) ? r_line + LINE_BITS'(1) : r_line;

    // Saturate a line count to 16 bits
    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+15:0] e;
        e = (LINE_BITS+16)'(v);
        return (e > (LINE_BITS+16)'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    // Saturate a depth to 5 bits
    function automatic logic [4:0] sat_depth(input logic [SP_W-1:0] v);
        logic [SP_W+4:0] e;
        e = (SP_W+5)'(v);
        return (e > (SP_W+5)'(31)) ? 5'd31 : e[4:0];
    endfunction

    // Status of a line that ends now
    function automatic t_status line_status(input t_status err, input t_phase ph,
                                            input logic first, input logic [23:0] rb);
        t_status s;
        s = ST_OK;
        if (err != ST_OK) begin
            s = err;
        end else begin
            unique case (ph)
                PH_START:                          s = first ? ST_PR_CLOSE : ST_TAG_OPEN;
                PH_PR_EQ, PH_PR_VAL:               s = ST_PR_QUOTE;
                PH_PR_Q, PH_PR_SCAN, PH_PR_FREE:
                    s = (rb[15:0] == {CH_QMARK, CH_GT}) ? ST_OK : ST_PR_CLOSE;
                PH_SEL, PH_CL_NAME, PH_OP_NAME:    s = ST_UNTERM;
                PH_CM2, PH_CM3:                    s = ST_CM_OPEN;
                PH_CM_BODY:
                    s = (rb == {CH_DASH, CH_DASH, CH_GT}) ? ST_OK : ST_CM_CLOSE;
                default:                           s = ST_OK;
            endcase
        end
        return s;
    endfunction

    // Parse one transaction
    always_comb begin
        logic [7:0]    b;
        logic [IW-1:0] idx;
        logic          do_open, do_close, do_fin_open, do_fin_close, do_begin;
        b            = i_text_byte;
        idx          = r_idx;
        do_open      = 1'b0;
        do_close     = 1'b0;
        do_fin_open  = 1'b0;
        do_fin_close = 1'b0;
        do_begin     = 1'b0;

        mis_now    = r_mis | (r_cmp_vld && (rd_data != r_cmp_byte));
        n_phase    = r_phase;
        n_err      = r_err;
        n_sp       = r_sp;
        n_line     = r_line;
        n_open     = r_open;
        n_recent   = r_recent;
        n_idx      = r_idx;
        n_mis      = mis_now;
        n_cmp_vld  = 1'b0;
        n_cmp_byte = b;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        len_we     = 1'b0;
        len_wa     = '0;
        len_wd     = '0;
        push0      = '0;
        push1      = '0;

        if (acc && i_end_of_document) begin
            // Finish the pending line, give the verdict, restart
            if (r_open) begin
                push0.vld = 1'b1;
                push0.res = '{sat_line(r_line),
                    line_status(r_err, r_phase, r_line == LINE_BITS'(1), r_recent),
                    sat_depth(r_sp), 1'b0};
                push1.vld = 1'b1;
                push1.res = '{sat_line(r_line),
                    (r_sp == '0) ? ST_DOC_OK : ST_UNBALANCED, sat_depth(r_sp), 1'b1};
            end else begin
                push0.vld = 1'b1;
                push0.res = '{sat_line(r_line),
                    (r_sp == '0) ? ST_DOC_OK : ST_UNBALANCED, sat_depth(r_sp), 1'b1};
            end
            n_sp = '0; n_line = '0; n_open = 1'b0; n_phase = PH_START;
            n_err = ST_OK; n_recent = '0; n_idx = '0; n_mis = 1'b0;
        end else if (acc && b == CH_LF) begin
            // Report the line and clear per-line state
            n_line    = line_eff;
            push0.vld = 1'b1;
            push0.res = '{sat_line(line_eff),
                line_status(r_err, r_phase, line_eff == LINE_BITS'(1), r_recent),
                sat_depth(r_sp), 1'b0};
            n_open = 1'b0; n_phase = PH_START; n_err = ST_OK;
            n_recent = '0; n_idx = '0; n_mis = 1'b0;
        end else if (acc) begin
            n_line   = line_eff;
            n_open   = 1'b1;
            n_recent = {r_recent[15:0], b};
            unique case (r_phase)
                PH_START: begin
                    if (line_eff == LINE_BITS'(1)) begin
                        n_phase = (b == CH_LT) ? PH_PR_Q : PH_PR_FREE;
                    end else if (b == CH_LT) begin
                        n_phase = PH_SEL;
                    end else begin
                        n_err = ST_TAG_OPEN; n_phase = PH_DONE;
                    end
                end
                PH_PR_Q:    n_phase = (b == CH_QMARK) ? PH_PR_SCAN : PH_PR_FREE;
                PH_PR_SCAN: if (b == CH_EQ) n_phase = PH_PR_EQ;
                PH_PR_EQ: begin
                    if (b == CH_QUOTE) n_phase = PH_PR_VAL;
                    else begin n_err = ST_PR_QUOTE; n_phase = PH_DONE; end
                end
                PH_PR_VAL: begin
                    if (b == CH_QUOTE) n_phase = PH_PR_SCAN;
                    else if (b == CH_EQ) begin n_err = ST_PR_QUOTE; n_phase = PH_DONE; end
                end
                PH_SEL: begin
                    if (b == CH_EXCL) begin
                        n_phase = PH_CM2;
                    end else if (b == CH_SLASH) begin
                        do_begin = 1'b1;
                    end else begin
                        idx     = '0;
                        n_phase = PH_OP_NAME;
                        if (b == CH_GT) do_fin_open = 1'b1;
                        else            do_open     = 1'b1;
                    end
                end
                PH_CM2: begin
                    if (b == CH_DASH) n_phase = PH_CM3;
                    else begin n_err = ST_CM_OPEN; n_phase = PH_DONE; end
                end
                PH_CM3: begin
                    if (b == CH_DASH) n_phase = PH_CM_BODY;
                    else begin n_err = ST_CM_OPEN; n_phase = PH_DONE; end
                end
                PH_OP_NAME: begin
                    if (b == CH_GT) do_fin_open = 1'b1;
                    else            do_open     = 1'b1;
                end
                PH_CL_NAME: begin
                    if (b == CH_GT) do_fin_close = 1'b1;
                    else            do_close     = 1'b1;
                end
                PH_OP_BODY: if (b == CH_SLASH && r_recent[7:0] == CH_LT) do_begin = 1'b1;
                default: ;
            endcase

            // Store an opening name byte
            if (do_open) begin
                if (idx < IW'(NAME_LEN) && r_sp < SP_W'(STACK_DEPTH)) begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(r_sp) * ADDR_W'(NAME_LEN) + ADDR_W'(idx);
                end
                n_idx = (idx <= IW'(NAME_LEN)) ? idx + IW'(1) : idx;
            end

            // Compare a closing name byte against the top name
            if (do_close) begin
                if (r_sp != '0 && idx < IW'(NAME_LEN)) begin
                    if (idx >= top_len) begin
                        n_mis = 1'b1;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = ADDR_W'(top) * ADDR_W'(NAME_LEN) + ADDR_W'(idx);
                        n_cmp_vld = 1'b1;
                    end
                end
                n_idx = (idx <= IW'(NAME_LEN)) ? idx + IW'(1) : idx;
            end

            // Push a complete opening name
            if (do_fin_open) begin
                n_idx = idx;
                if (idx > IW'(NAME_LEN)) begin
                    n_err = ST_NAME_LONG; n_phase = PH_DONE;
                end else if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    n_err = ST_OVERFLOW; n_phase = PH_DONE;
                end else begin
                    len_we  = 1'b1;
                    len_wa  = r_sp[TOP_W-1:0];
                    len_wd  = idx;
                    n_sp    = r_sp + SP_W'(1);
                    n_phase = PH_OP_BODY;
                end
            end

            // Pop on a complete closing name
            if (do_fin_close) begin
                if (idx > IW'(NAME_LEN)) begin
                    if (r_sp != '0) n_sp = top;
                    n_err = ST_NAME_LONG; n_phase = PH_DONE;
                end else if (r_sp == '0) begin
                    n_err = ST_MISMATCH; n_phase = PH_DONE;
                end else begin
                    n_sp    = top;
                    n_phase = PH_DONE;
                    if (mis_now || idx != top_len) n_err = ST_MISMATCH;
                end
            end

            // Start a closing name
            if (do_begin) begin
                n_idx = '0; n_mis = 1'b0; n_phase = PH_CL_NAME;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_err     <= ST_OK;
            r_sp      <= '0;
            r_line    <= '0;
            r_open    <= 1'b0;
            r_recent  <= '0;
            r_idx     <= '0;
            r_mis     <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_err     <= n_err;
            r_sp      <= n_sp;
            r_line    <= n_line;
            r_open    <= n_open;
            r_recent  <= n_recent;
            r_idx     <= n_idx;
            r_mis     <= n_mis;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Hold compare byte and name lengths
    always_ff @(posedge i_clk) begin
        r_cmp_byte <= n_cmp_byte;
        if (len_we) begin
            r_len[len_wa] <= len_wd;
        end
    end

    xtn_name_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_name_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_text_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign pop = o_valid && i_ready;

    xtn_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_cnt)
    );

    assign o_valid       = (q_cnt != 3'd0);
    assign o_line_number = head.line_number;
    assign o_status      = head.status;
    assign o_open_depth  = head.open_depth;
    assign o_last_result = head.last_result;

`ifndef NO_ASSERTIONS
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_doc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_end_of_document) |=> (r_sp == '0 && r_line == '0 && !r_open))
        else $error("state not cleared after document end");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt <= 3'd4)
        else $error("result queue overrun");

    a_no_wr_rd_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("name memory written and read together");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XML tag nesting checker. A directed table of
// bytes and document ends runs first, then randomly generated documents:
// mostly well-formed prolog, tag, comment and same-line lines with random
// names and text, mixed with broken lines, long names, deep nesting and noise.
// Every accepted transaction runs through a line-status predictor, and every
// result transaction is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
    import xtn_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int NAME_LEN    = 32;
    localparam int LINE_MAX    = 65535;
    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_text_byte;
    logic        i_end_of_document;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_line_number;
    logic [3:0]  o_status;
    logic [4:0]  o_open_depth;
    logic        o_last_result;

    xml_tag_nesting_checker i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_text_byte       (i_text_byte),
        .i_end_of_document (i_end_of_document),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_line_number     (o_line_number),
        .o_status          (o_status),
        .o_open_depth      (o_open_depth),
        .o_last_result     (o_last_result)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Directed rows: byte, document end, typed status check, status
    typedef struct packed {
        logic [7:0] text;
        logic       eod;
        logic       chk;
        t_status    st;
    } t_row;

    localparam int DIR_ROWS = 21;
    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        // prolog with only the closing mark
        '{CH_QMARK, 1'b0, 1'b0, ST_OK},
        '{CH_GT,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b1, ST_OK},
        // open tag
        '{CH_LT,    1'b0, 1'b0, ST_OK},
        '{8'h61,    1'b0, 1'b0, ST_OK},
        '{CH_GT,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b1, ST_OK},
        // wrong closing name
        '{CH_LT,    1'b0, 1'b0, ST_OK},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK},
        '{8'h62,    1'b0, 1'b0, ST_OK},
        '{CH_GT,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b1, ST_MISMATCH},
        // line not starting with '<'
        '{8'hFF,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b1, ST_TAG_OPEN},
        // lone '<'
        '{CH_LT,    1'b0, 1'b0, ST_OK},
        '{CH_LF,    1'b0, 1'b1, ST_UNTERM},
        // empty line after the prolog
        '{CH_LF,    1'b0, 1'b1, ST_TAG_OPEN},
        '{8'h00,    1'b1, 1'b1, ST_DOC_OK},
        // pending prolog line at document end, then an empty document
        '{8'h00,    1'b0, 1'b0, ST_OK},
        '{8'hFF,    1'b1, 1'b0, ST_OK},
        '{8'h5A,    1'b1, 1'b1, ST_DOC_OK}
    };

    // ------------------------------------------------------------------
    // Line-status predictor
    // ------------------------------------------------------------------
    logic [7:0]  name_mem [STACK_DEPTH][NAME_LEN];
    int          name_len [STACK_DEPTH];
    int          depth;
    int          line_cnt;
    int          col_cnt;
    t_phase      phase;
    logic [23:0] tail;
    int          idx;
    t_status     line_err;
    bit          cmp_bad;

    t_result     expected_q [$];

    task automatic clear_line();
        col_cnt  = 0;
        phase    = PH_START;
        tail     = '0;
        idx      = 0;
        line_err = ST_OK;
        cmp_bad  = 1'b0;
    endtask

    task automatic clear_doc();
        depth    = 0;
        line_cnt = 0;
        clear_line();
    endtask

    task automatic reject_line(input t_status code);
        line_err = code;
        phase    = PH_DONE;
    endtask

    task automatic queue_result(input t_status st, input logic last);
        t_result r;
        r.line_number = (line_cnt > 65535) ? 16'hFFFF : 16'(line_cnt);
        r.status      = st;
        r.open_depth  = (depth > 31) ? 5'd31 : 5'(depth);
        r.last_result = last;
        expected_q.push_back(r);
    endtask

    function automatic t_status pending_status();
        if (line_err != ST_OK) begin
            return line_err;
        end
        case (phase)
            PH_START:                        return (line_cnt == 1) ? ST_PR_CLOSE : ST_TAG_OPEN;
            PH_PR_EQ, PH_PR_VAL:             return ST_PR_QUOTE;
            PH_PR_Q, PH_PR_SCAN, PH_PR_FREE: begin
                return (tail[15:0] == {CH_QMARK, CH_GT}) ? ST_OK : ST_PR_CLOSE;
            end
            PH_SEL, PH_CL_NAME, PH_OP_NAME:  return ST_UNTERM;
            PH_CM2, PH_CM3:                  return ST_CM_OPEN;
            PH_CM_BODY: begin
                return (tail == {CH_DASH, CH_DASH, CH_GT}) ? ST_OK : ST_CM_CLOSE;
            end
            default:                         return ST_OK;
        endcase
    endfunction

    task automatic advance_idx();
        if (idx <= NAME_LEN) begin
            idx++;
        end
    endtask

    task automatic store_open_byte(input logic [7:0] b);
        if (idx < NAME_LEN && depth < STACK_DEPTH) begin
            name_mem[depth][idx] = b;
        end
        advance_idx();
    endtask

    task automatic compare_close_byte(input logic [7:0] b);
        if (depth > 0 && idx < NAME_LEN) begin
            if (idx >= name_len[depth-1] || name_mem[depth-1][idx] != b) begin
                cmp_bad = 1'b1;
            end
        end
        advance_idx();
    endtask

    task automatic push_name();
        if (idx > NAME_LEN) begin
            reject_line(ST_NAME_LONG);
        end else if (depth >= STACK_DEPTH) begin
            reject_line(ST_OVERFLOW);
        end else begin
            name_len[depth] = idx;
            depth++;
            phase = PH_OP_BODY;
        end
    endtask

    task automatic pop_name();
        bit ok;
        if (idx > NAME_LEN) begin
            if (depth > 0) begin
                depth--;
            end
            reject_line(ST_NAME_LONG);
        end else if (depth == 0) begin
            reject_line(ST_MISMATCH);
        end else begin
            ok = !cmp_bad && idx == name_len[depth-1];
            depth--;
            if (ok) begin
                phase = PH_DONE;
            end else begin
                reject_line(ST_MISMATCH);
            end
        end
    endtask

    task automatic start_close();
        idx     = 0;
        cmp_bad = 1'b0;
        phase   = PH_CL_NAME;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic [7:0] prev);
        case (phase)
            PH_START: begin
                if (line_cnt == 1) begin
                    phase = (b == CH_LT) ? PH_PR_Q : PH_PR_FREE;
                end else if (b == CH_LT) begin
                    phase = PH_SEL;
                end else begin
                    reject_line(ST_TAG_OPEN);
                end
            end
            PH_PR_Q:    phase = (b == CH_QMARK) ? PH_PR_SCAN : PH_PR_FREE;
            PH_PR_SCAN: if (b == CH_EQ) phase = PH_PR_EQ;
            PH_PR_EQ: begin
                if (b == CH_QUOTE) phase = PH_PR_VAL;
                else reject_line(ST_PR_QUOTE);
            end
            PH_PR_VAL: begin
                if (b == CH_QUOTE) phase = PH_PR_SCAN;
                else if (b == CH_EQ) reject_line(ST_PR_QUOTE);
            end
            PH_SEL: begin
                if (b == CH_EXCL) begin
                    phase = PH_CM2;
                end else if (b == CH_SLASH) begin
                    start_close();
                end else begin
                    idx   = 0;
                    phase = PH_OP_NAME;
                    if (b == CH_GT) push_name();
                    else store_open_byte(b);
                end
            end
            PH_CM2: begin
                if (b == CH_DASH) phase = PH_CM3;
                else reject_line(ST_CM_OPEN);
            end
            PH_CM3: begin
                if (b == CH_DASH) phase = PH_CM_BODY;
                else reject_line(ST_CM_OPEN);
            end
            PH_OP_NAME: begin
                if (b == CH_GT) push_name();
                else store_open_byte(b);
            end
            PH_CL_NAME: begin
                if (b == CH_GT) pop_name();
                else compare_close_byte(b);
            end
            PH_OP_BODY: if (b == CH_SLASH && prev == CH_LT) start_close();
            default: ;
        endcase
    endtask

    // Predict the results of one accepted transaction
    task automatic predict_line_status(input logic [7:0] b, input logic eod);
        if (eod) begin
            if (col_cnt > 0) begin
                queue_result(pending_status(), 1'b0);
            end
            queue_result((depth == 0) ? ST_DOC_OK : ST_UNBALANCED, 1'b1);
            clear_doc();
        end else begin
            if (col_cnt == 0 && line_cnt < LINE_MAX) begin
                line_cnt++;
            end
            if (b == CH_LF) begin
                queue_result(pending_status(), 1'b0);
                clear_line();
            end else begin
                if (col_cnt < 65535) begin
                    col_cnt++;
                end
                parse_byte(b, tail[7:0]);
                tail = {tail[15:0], b};
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Random document generator
    // ------------------------------------------------------------------
    logic [7:0] stim_byte [$];
    logic       stim_eod  [$];
    logic [7:0] gen_name  [STACK_DEPTH][40];
    int         gen_len   [STACK_DEPTH];
    int         gen_depth;

    task automatic put(input logic [7:0] b, input logic eod);
        stim_byte.push_back(b);
        stim_eod.push_back(eod);
    endtask

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++) begin
            put(s[k], 1'b0);
        end
    endtask

    // Text without line breaks, biased toward markup characters
    task automatic put_text(input int n);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: b = CH_LT;
                1: b = CH_SLASH;
                2: b = 8'h20;
                default: b = 8'h61 + 8'($urandom_range(0, 25));
            endcase
            put(b, 1'b0);
        end
    endtask

    // Fill a name slot with letters, or with any byte that is legal in a name
    task automatic make_name(input int slot, input int n);
        logic [7:0] b;
        bit wild;
        wild = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++) begin
            b = wild ? 8'($urandom_range(0, 255)) : 8'h61 + 8'($urandom_range(0, 25));
            if (b == CH_LF || b == CH_GT || (k == 0 && (b == CH_EXCL || b == CH_SLASH))) begin
                b = 8'h7A;
            end
            gen_name[slot][k] = b;
        end
        gen_len[slot] = n;
    endtask

    task automatic put_name(input int slot);
        for (int k = 0; k < gen_len[slot]; k++) begin
            put(gen_name[slot][k], 1'b0);
        end
    endtask

    task automatic put_open(input int slot);
        put(CH_LT, 1'b0);
        put_name(slot);
        put(CH_GT, 1'b0);
    endtask

    task automatic put_close(input int slot);
        put(CH_LT, 1'b0);
        put(CH_SLASH, 1'b0);
        put_name(slot);
        put(CH_GT, 1'b0);
    endtask

    task automatic gen_document();
        int lines;
        int r;
        int slot;
        gen_depth = 0;
        lines = $urandom_range(2, 40);
        // prolog line
        case ($urandom_range(0, 7))
            0, 1, 2, 3: put_str("<?xml version=\"1.0\" enc=\"u\"?>");
            4:          put_str("<?xml v=1?>");
            5:          put_str("<?a=\"x=y\"?>");
            6:          put_text($urandom_range(0, 6));
            default:    put_str("<?a=\"open");
        endcase
        put(CH_LF, 1'b0);
        for (int ln = 0; ln < lines; ln++) begin
            r = $urandom_range(0, 99);
            slot = (gen_depth < STACK_DEPTH) ? gen_depth : STACK_DEPTH - 1;
            if (r < 34) begin
                // open a tag, deep nesting is allowed to overflow
                make_name(slot, $urandom_range(1, 6));
                put_open(slot);
                if ($urandom_range(0, 3) == 0) put_text($urandom_range(1, 5));
                if (gen_depth < STACK_DEPTH) gen_depth++;
            end else if (r < 60 && gen_depth > 0) begin
                put_close(gen_depth - 1);
                gen_depth--;
            end else if (r < 70) begin
                // open and close on one line, the close sometimes corrupted
                make_name(slot, $urandom_range(1, 6));
                put_open(slot);
                put_text($urandom_range(0, 4));
                if ($urandom_range(0, 4) == 0) gen_name[slot][0] ^= 8'h01;
                put_close(slot);
                if ($urandom_range(0, 3) == 0) put_text($urandom_range(1, 3));
            end else if (r < 78) begin
                case ($urandom_range(0, 5))
                    0:       put_str("<!-x -->");
                    1:       put_str("<!-- open");
                    default: begin
                        put_str("<!--");
                        put_text($urandom_range(0, 6));
                        put_str("-->");
                    end
                endcase
            end else if (r < 84) begin
                // name just below, at or beyond the length limit
                make_name(slot, $urandom_range(NAME_LEN - 1, NAME_LEN + 8));
                if ($urandom_range(0, 1) == 0 || gen_depth == 0) begin
                    put_open(slot);
                    if (gen_len[slot] <= NAME_LEN && gen_depth < STACK_DEPTH) gen_depth++;
                end else begin
                    put_close(slot);
                    gen_depth--;
                end
            end else if (r < 89) begin
                put_str("</q>");
                if (gen_depth > 0) gen_depth--;
            end else if (r < 95) begin
                for (int k = $urandom_range(1, 8); k > 0; k--) begin
                    put(8'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                make_name(slot, $urandom_range(0, 4));
                put(CH_LT, 1'b0);
                put_name(slot);
            end
            // rarely end the document in the middle of a line
            if ($urandom_range(0, 39) == 0) break;
            put(CH_LF, 1'b0);
        end
        if ($urandom_range(0, 1) == 0) begin
            while (gen_depth > 0) begin
                put_close(gen_depth - 1);
                put(CH_LF, 1'b0);
                gen_depth--;
            end
        end
        put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int  errors;
    int  cycles;
    bit  hold_off;

    task automatic send_item(input logic [7:0] b, input logic eod, output int first_idx);
        i_valid           <= 1'b1;
        i_text_byte       <= b;
        i_end_of_document <= eod;
        do @(posedge i_clk); while (!o_ready);
        first_idx = expected_q.size();
        predict_line_status(b, eod);
    endtask

    initial begin
        int burst;
        int first;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_text_byte       <= '0;
        i_end_of_document <= 1'b0;
        errors  = 0;
        clear_doc();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIR_TABLE[i].text, DIR_TABLE[i].eod, first);
            if (DIR_TABLE[i].chk && expected_q[first].status != DIR_TABLE[i].st) begin
                $display("%0t: row %0d status expected %0d, predicted %0d", $time, i,
                         DIR_TABLE[i].st, expected_q[first].status);
                errors++;
            end
        end

        // Random documents, driven in bursts
        while (stim_byte.size() < ITEM_TARGET) begin
            gen_document();
        end
        burst = 0;
        for (int i = 0; i < stim_byte.size(); i++) begin
            if (burst == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
            end
            send_item(stim_byte[i], stim_eod[i], first);
            burst--;
        end
        i_valid <= 1'b0;

        // Drain
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern plus one long hold-off while input streams
    // ------------------------------------------------------------------
    initial begin
        hold_off = 1'b0;
        repeat (1000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_ready <= 1'b0;
        end else begin
            case ((cycles / 150) % 3)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 1);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker and run limit
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result line %0d status %0d", $time,
                         o_line_number, o_status);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_line_number !== exp_r.line_number) begin
                    $display("%0t: line_number expected %0d, actual %0d", $time,
                             exp_r.line_number, o_line_number);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d, actual %0d", $time,
                             exp_r.status, o_status);
                    errors++;
                end
                if (o_open_depth !== exp_r.open_depth) begin
                    $display("%0t: open_depth expected %0d, actual %0d", $time,
                             exp_r.open_depth, o_open_depth);
                    errors++;
                end
                if (o_last_result !== exp_r.last_result) begin
                    $display("%0t: last_result expected %0d, actual %0d", $time,
                             exp_r.last_result, o_last_result);
                    errors++;
                end
            end
        end
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

FILE: sim.f
sv/xtn_pkg.sv
sv/xtn_name_mem.sv
sv/xtn_out_fifo.sv
sv/xml_tag_nesting_checker.sv
test/testbench.sv
